>>> design/vtp_pkg.sv
package vtp_pkg;

  // Rotation datapath width: offsets grow by about two bits per axis pass
  localparam int RW = 38;
  // Projection numerator, denominator and quotient widths
  localparam int NW = 66;
  localparam int DW = 50;
  localparam int QW = 16;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PROJECT   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_PIVOT_X   = 3'd0,
    CFG_PIVOT_Y   = 3'd1,
    CFG_PIVOT_Z   = 3'd2,
    CFG_VIEW_DIST = 3'd3,
    CFG_CENTER_X  = 3'd4,
    CFG_CENTER_Y  = 3'd5
  } cfg_reg_t;

  // Values that ride along the divider
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
    logic               proj;
    logic               zero;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic signed [NW-1:0]   num_x;
    logic signed [NW-1:0]   num_y;
    logic signed [DW-1:0]   den;
  } div_in_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               fault;
    logic               last;
  } div_out_t;

  // Clamp to 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // First-quadrant sine of k table steps, unsigned Q1.16; evaluated at elaboration only
  function automatic logic [16:0] quarter_sine(input int k, input int tb);
    logic [63:0]        xv;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 n;
    xv   = (HALF_PI_Q30 * 64'(k)) >> (tb - 2);
    term = xv;
    sum  = $signed(xv);
    for (n = 1; n <= 7; n++) begin
      term = (term * xv) >> 30;
      term = (term * xv) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd65536) begin
      sum = 64'sd65536;
    end
    return 17'(sum);
  endfunction

endpackage

>>> design/vtp_trig.sv
module vtp_trig #(
  parameter int TB = 10
) (
  input  logic [15:0]        angle,
  output logic signed [17:0] sin_v,
  output logic signed [17:0] cos_v
);

  localparam int QN = 1 << (TB - 2);
  localparam logic [TB-2:0] QN_V = (TB - 1)'(QN);
  localparam logic [TB-1:0] QUARTER = TB'(QN);

  // Quarter-wave table, one entry past the quadrant end
  logic [16:0] qtab [QN+1];

  for (genvar k = 0; k <= QN; k++) begin : g_tab
    localparam logic [16:0] QV = vtp_pkg::quarter_sine(k, TB);
    assign qtab[k] = QV;
  end

  // Fold the full turn onto the quarter table
  function automatic logic signed [17:0] lookup(input logic [TB-1:0] idx);
    logic [1:0]    quad;
    logic [TB-3:0] r;
    logic [TB-2:0] ri;
    logic [16:0]   mag;
    quad = idx[TB-1:TB-2];
    r    = idx[TB-3:0];
    if (quad[0]) begin
      ri = QN_V - {1'b0, r};
    end else begin
      ri = {1'b0, r};
    end
    mag = qtab[ri];
    if (quad[1]) begin
      return -$signed({1'b0, mag});
    end else begin
      return $signed({1'b0, mag});
    end
  endfunction

  logic [TB-1:0] idx;

  assign idx   = angle[15:16-TB];
  assign sin_v = lookup(idx);
  assign cos_v = lookup(idx + QUARTER);

endmodule

>>> design/vtp_rot.sv
module vtp_rot (
  input  logic                          clk,
  input  logic                          en_prod,
  input  logic                          en_sum,
  input  logic signed [vtp_pkg::RW-1:0] u,
  input  logic signed [vtp_pkg::RW-1:0] w,
  input  logic signed [17:0]            s,
  input  logic signed [17:0]            c,
  output logic signed [vtp_pkg::RW-1:0] u_out,
  output logic signed [vtp_pkg::RW-1:0] w_out
);

  localparam int RW = vtp_pkg::RW;
  localparam int PW = RW + 18;
  localparam logic signed [PW:0] HALF = (PW + 1)'(32768);

  logic signed [PW-1:0] uc, ws, us, wc;
  logic signed [PW:0]   du, dw;
  logic signed [RW-1:0] u_out_next, w_out_next;

  // u' = u*c - w*s, w' = u*s + w*c, each rounded half up
  always_comb begin
    du         = (PW + 1)'(uc) - (PW + 1)'(ws) + HALF;
    dw         = (PW + 1)'(us) + (PW + 1)'(wc) + HALF;
    u_out_next = du[RW+15:16];
    w_out_next = dw[RW+15:16];
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      uc <= u * c;
      ws <= w * s;
      us <= u * s;
      wc <= w * c;
    end
    if (en_sum) begin
      u_out <= u_out_next;
      w_out <= w_out_next;
    end
  end

endmodule

>>> design/vtp_div.sv
module vtp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vtp_pkg::div_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vtp_pkg::div_out_t  out_data
);

  localparam int NW   = vtp_pkg::NW;
  localparam int DW   = vtp_pkg::DW;
  localparam int NB   = vtp_pkg::QW;
  localparam int LAST = NB + 1;

  logic [LAST:0]   v;
  logic [LAST+1:0] en;

  vtp_pkg::side_t side [0:NB];
  logic [NW-1:0]  rem_x [0:NB-1];
  logic [NW-1:0]  rem_y [0:NB-1];
  logic [DW-1:0]  dmag  [0:NB-1];
  logic [NB-1:0]  q_x   [0:NB];
  logic [NB-1:0]  q_y   [0:NB];
  logic           neg_x [0:NB];
  logic           neg_y [0:NB];
  logic           big_x [0:NB];
  logic           big_y [0:NB];

  vtp_pkg::div_out_t out_r, out_r_next;

  // Per-stage load enables; a stage loads when empty or draining
  always_comb begin
    en[LAST+1] = out_ready;
    for (int k = LAST; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[LAST];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Magnitudes, quotient sign and range check
  logic [NW-1:0] nabs_x, nabs_y, dlim;
  logic [DW-1:0] dabs;

  always_comb begin
    nabs_x = in_data.num_x[NW-1] ? NW'(-in_data.num_x) : NW'(in_data.num_x);
    nabs_y = in_data.num_y[NW-1] ? NW'(-in_data.num_y) : NW'(in_data.num_y);
    dabs   = in_data.den[DW-1] ? DW'(-in_data.den) : DW'(in_data.den);
    dlim   = {dabs, {(NW - DW){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0]  <= in_data.side;
      rem_x[0] <= nabs_x;
      rem_y[0] <= nabs_y;
      dmag[0]  <= dabs;
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      neg_x[0] <= in_data.num_x[NW-1] ^ in_data.den[DW-1];
      neg_y[0] <= in_data.num_y[NW-1] ^ in_data.den[DW-1];
      big_x[0] <= nabs_x >= dlim;
      big_y[0] <= nabs_y >= dlim;
    end
  end

  // One restoring quotient bit per stage, most significant first
  for (genvar k = 1; k <= NB; k++) begin : g_bit
    localparam int B = NB - k;
    logic [NW-1:0] trial;
    logic          take_x, take_y;

    assign trial  = {{(NW - DW){1'b0}}, dmag[k-1]} << B;
    assign take_x = rem_x[k-1] >= trial;
    assign take_y = rem_y[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side[k]  <= side[k-1];
        q_x[k]   <= q_x[k-1] | (NB'(take_x) << B);
        q_y[k]   <= q_y[k-1] | (NB'(take_y) << B);
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
        big_x[k] <= big_x[k-1];
        big_y[k] <= big_y[k-1];
      end
    end

    if (k < NB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_x[k] <= take_x ? rem_x[k-1] - trial : rem_x[k-1];
          rem_y[k] <= take_y ? rem_y[k-1] - trial : rem_y[k-1];
          dmag[k]  <= dmag[k-1];
        end
      end
    end
  end

  // Signed, saturated 16-bit pixel from magnitude quotient
  function automatic logic signed [15:0] pixel(input logic [NB-1:0] q, input logic neg,
                                               input logic big);
    if (neg) begin
      if (big || q > 16'd32768) begin
        return 16'sh8000;
      end else begin
        return $signed(16'(-q));
      end
    end else begin
      if (big || q > 16'd32767) begin
        return 16'sh7fff;
      end else begin
        return $signed(q);
      end
    end
  endfunction

  // Result assembly
  always_comb begin
    out_r_next.x     = side[NB].x;
    out_r_next.y     = side[NB].y;
    out_r_next.z     = side[NB].z;
    out_r_next.last  = side[NB].last;
    out_r_next.fault = side[NB].proj && side[NB].zero;
    if (side[NB].proj && !side[NB].zero) begin
      out_r_next.sx = pixel(q_x[NB], neg_x[NB], big_x[NB]);
      out_r_next.sy = pixel(q_y[NB], neg_y[NB], big_y[NB]);
    end else begin
      out_r_next.sx = '0;
      out_r_next.sy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_r <= out_r_next;
    end
  end

endmodule

>>> design/vertex_transform_project.sv
// Pipeline: 26 register stages from the accepting edge to m_axis_tvalid:
//   8 transform stages, then 18 divider stages for the perspective quotient.
// Throughput: one vertex per cycle unless m_axis_tready stalls the output; every
//   stage has its own valid bit and refills its bubble even while the output waits.
// Reset (rst, synchronous): clears all valid bits and loads the register reset values.
module vertex_transform_project #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // x_in, y_in, z_in, arg_x, arg_y, arg_z
  input  logic [1:0]   s_axis_tuser,  // mode
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // x_out, y_out, z_out, screen_x, screen_y
  output logic [0:0]   m_axis_tuser,  // divide_fault
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int RW = vtp_pkg::RW;
  localparam int NW = vtp_pkg::NW;
  localparam int DW = vtp_pkg::DW;

  // Configuration registers
  logic signed [31:0] pivot_x, pivot_y, pivot_z;
  logic [30:0]        viewport_distance;
  logic [11:0]        screen_center_x, screen_center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x           <= '0;
      pivot_y           <= '0;
      pivot_z           <= '0;
      viewport_distance <= 31'd16777216;
      screen_center_x   <= 12'd320;
      screen_center_y   <= 12'd240;
    end else if (cfg_valid) begin
      case (cfg_index)
        vtp_pkg::CFG_PIVOT_X:   pivot_x <= cfg_data;
        vtp_pkg::CFG_PIVOT_Y:   pivot_y <= cfg_data;
        vtp_pkg::CFG_PIVOT_Z:   pivot_z <= cfg_data;
        vtp_pkg::CFG_VIEW_DIST: viewport_distance <= cfg_data[30:0];
        vtp_pkg::CFG_CENTER_X:  screen_center_x <= cfg_data[11:0];
        vtp_pkg::CFG_CENTER_Y:  screen_center_y <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Input fields
  vtp_pkg::mode_t     in_mode;
  logic signed [31:0] x_in, y_in, z_in, arg_x, arg_y, arg_z;

  assign in_mode = vtp_pkg::mode_t'(s_axis_tuser);
  assign x_in    = s_axis_tdata[31:0];
  assign y_in    = s_axis_tdata[63:32];
  assign z_in    = s_axis_tdata[95:64];
  assign arg_x   = s_axis_tdata[127:96];
  assign arg_y   = s_axis_tdata[159:128];
  assign arg_z   = s_axis_tdata[191:160];

  // Sine and cosine of the three angles
  logic signed [17:0] sin_xa, cos_xa, sin_ya, cos_ya, sin_za, cos_za;

  vtp_trig #(.TB(SINE_TABLE_BITS)) u_trig_x (
    .angle(arg_x[15:0]), .sin_v(sin_xa), .cos_v(cos_xa)
  );
  vtp_trig #(.TB(SINE_TABLE_BITS)) u_trig_y (
    .angle(arg_y[15:0]), .sin_v(sin_ya), .cos_v(cos_ya)
  );
  vtp_trig #(.TB(SINE_TABLE_BITS)) u_trig_z (
    .angle(arg_z[15:0]), .sin_v(sin_za), .cos_v(cos_za)
  );

  // Stage handshake
  logic [8:1] v;
  logic [9:1] en;
  logic       div_ready;

  always_comb begin
    en[9] = div_ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Pipeline registers
  vtp_pkg::mode_t     mode_r [1:8];
  logic               last_r [1:8];
  logic signed [31:0] rx     [1:8];
  logic signed [31:0] ry     [1:8];
  logic signed [31:0] rz     [1:8];
  logic signed [31:0] ox_r   [1:3];
  logic signed [31:0] off_y1, off_z1, ax1, ay1, az1;
  logic signed [17:0] sin_x1, cos_x1;
  logic signed [17:0] sin_y  [1:3];
  logic signed [17:0] cos_y  [1:3];
  logic signed [17:0] sin_z  [1:5];
  logic signed [17:0] cos_z  [1:5];
  logic signed [33:0] d1, d2;
  logic signed [63:0] sc_x2, sc_y2, sc_z2, pvx2, pvy2;
  logic signed [46:0] pcx2, pcy2;
  logic               zero   [2:8];
  logic signed [NW-1:0] numx [3:8];
  logic signed [NW-1:0] numy [3:8];
  logic signed [DW-1:0] den  [3:8];
  logic signed [RW-1:0] yc   [4:5];
  logic signed [RW-1:0] zc   [6:7];

  // Rotation passes: X in stages 2-3, Y in 4-5, Z in 6-7
  logic signed [RW-1:0] z1, y1, x2, z2, x3, y3;

  vtp_rot u_rot_x (
    .clk(clk), .en_prod(en[2]), .en_sum(en[3]),
    .u(RW'(off_z1)), .w(RW'(off_y1)), .s(sin_x1), .c(cos_x1),
    .u_out(z1), .w_out(y1)
  );
  vtp_rot u_rot_y (
    .clk(clk), .en_prod(en[4]), .en_sum(en[5]),
    .u(RW'(ox_r[3])), .w(z1), .s(sin_y[3]), .c(cos_y[3]),
    .u_out(x2), .w_out(z2)
  );
  vtp_rot u_rot_z (
    .clk(clk), .en_prod(en[6]), .en_sum(en[7]),
    .u(x2), .w(yc[5]), .s(sin_z[5]), .c(cos_z[5]),
    .u_out(x3), .w_out(y3)
  );

  // Scale: round the product, re-add the pivot, clamp
  function automatic logic signed [31:0] scale_one(input logic signed [63:0] p,
                                                   input logic signed [31:0] piv);
    logic signed [64:0] t;
    t = (65'(p) + 65'sd32768) >>> 16;
    return vtp_pkg::sat32(50'(t) + 50'(piv));
  endfunction

  always_ff @(posedge clk) begin
    // Stage 1: offsets, translation, trig lookup, projection denominator
    if (en[1]) begin
      mode_r[1] <= in_mode;
      last_r[1] <= s_axis_tlast;
      if (in_mode == vtp_pkg::MODE_TRANSLATE) begin
        rx[1] <= vtp_pkg::sat32(50'(x_in) + 50'(arg_x));
        ry[1] <= vtp_pkg::sat32(50'(y_in) + 50'(arg_y));
        rz[1] <= vtp_pkg::sat32(50'(z_in) + 50'(arg_z));
      end else begin
        rx[1] <= x_in;
        ry[1] <= y_in;
        rz[1] <= z_in;
      end
      ox_r[1]  <= vtp_pkg::sat32(50'(x_in) - 50'(pivot_x));
      off_y1   <= vtp_pkg::sat32(50'(y_in) - 50'(pivot_y));
      off_z1   <= vtp_pkg::sat32(50'(z_in) - 50'(pivot_z));
      ax1      <= arg_x;
      ay1      <= arg_y;
      az1      <= arg_z;
      sin_x1   <= sin_xa;
      cos_x1   <= cos_xa;
      sin_y[1] <= sin_ya;
      cos_y[1] <= cos_ya;
      sin_z[1] <= sin_za;
      cos_z[1] <= cos_za;
      d1       <= 34'(z_in) + 34'($signed({1'b0, viewport_distance}));
    end

    // Stage 2: scale and projection products
    if (en[2]) begin
      mode_r[2] <= mode_r[1];
      last_r[2] <= last_r[1];
      rx[2]     <= rx[1];
      ry[2]     <= ry[1];
      rz[2]     <= rz[1];
      ox_r[2]   <= ox_r[1];
      sin_y[2]  <= sin_y[1];
      cos_y[2]  <= cos_y[1];
      sin_z[2]  <= sin_z[1];
      cos_z[2]  <= cos_z[1];
      sc_x2     <= ox_r[1] * ax1;
      sc_y2     <= off_y1 * ay1;
      sc_z2     <= off_z1 * az1;
      pvx2      <= rx[1] * $signed({1'b0, viewport_distance});
      pvy2      <= ry[1] * $signed({1'b0, viewport_distance});
      pcx2      <= d1 * $signed({1'b0, screen_center_x});
      pcy2      <= d1 * $signed({1'b0, screen_center_y});
      d2        <= d1;
      zero[2]   <= (d1 == '0);
    end

    // Stage 3: scale results, projection numerators
    if (en[3]) begin
      mode_r[3] <= mode_r[2];
      last_r[3] <= last_r[2];
      if (mode_r[2] == vtp_pkg::MODE_SCALE) begin
        rx[3] <= scale_one(sc_x2, pivot_x);
        ry[3] <= scale_one(sc_y2, pivot_y);
        rz[3] <= scale_one(sc_z2, pivot_z);
      end else begin
        rx[3] <= rx[2];
        ry[3] <= ry[2];
        rz[3] <= rz[2];
      end
      ox_r[3]  <= ox_r[2];
      sin_y[3] <= sin_y[2];
      cos_y[3] <= cos_y[2];
      sin_z[3] <= sin_z[2];
      cos_z[3] <= cos_z[2];
      zero[3]  <= zero[2];
      numx[3]  <= NW'(pvx2) + (NW'(pcx2) <<< 16);
      numy[3]  <= (NW'(pcy2) <<< 16) - NW'(pvy2);
      den[3]   <= DW'(d2) <<< 16;
    end

    // Stages 4-7: carry payload alongside the rotation units
    for (int k = 4; k <= 7; k++) begin
      if (en[k]) begin
        mode_r[k] <= mode_r[k-1];
        last_r[k] <= last_r[k-1];
        rx[k]     <= rx[k-1];
        ry[k]     <= ry[k-1];
        rz[k]     <= rz[k-1];
        zero[k]   <= zero[k-1];
        numx[k]   <= numx[k-1];
        numy[k]   <= numy[k-1];
        den[k]    <= den[k-1];
      end
    end
    for (int k = 4; k <= 5; k++) begin
      if (en[k]) begin
        sin_z[k] <= sin_z[k-1];
        cos_z[k] <= cos_z[k-1];
      end
    end
    if (en[4]) begin
      yc[4] <= y1;
    end
    if (en[5]) begin
      yc[5] <= yc[4];
    end
    if (en[6]) begin
      zc[6] <= z2;
    end
    if (en[7]) begin
      zc[7] <= zc[6];
    end

    // Stage 8: rotation back to world space
    if (en[8]) begin
      mode_r[8] <= mode_r[7];
      last_r[8] <= last_r[7];
      zero[8]   <= zero[7];
      numx[8]   <= numx[7];
      numy[8]   <= numy[7];
      den[8]    <= den[7];
      if (mode_r[7] == vtp_pkg::MODE_ROTATE) begin
        rx[8] <= vtp_pkg::sat32(50'(x3) + 50'(pivot_x));
        ry[8] <= vtp_pkg::sat32(50'(y3) + 50'(pivot_y));
        rz[8] <= vtp_pkg::sat32(50'(zc[7]) + 50'(pivot_z));
      end else begin
        rx[8] <= rx[7];
        ry[8] <= ry[7];
        rz[8] <= rz[7];
      end
    end
  end

  // Perspective divide and output register
  vtp_pkg::div_in_t  div_in;
  vtp_pkg::div_out_t div_out;

  always_comb begin
    div_in.side.x    = rx[8];
    div_in.side.y    = ry[8];
    div_in.side.z    = rz[8];
    div_in.side.last = last_r[8];
    div_in.side.proj = (mode_r[8] == vtp_pkg::MODE_PROJECT);
    div_in.side.zero = zero[8];
    div_in.num_x     = numx[8];
    div_in.num_y     = numy[8];
    div_in.den       = den[8];
  end

  vtp_div u_div (
    .clk(clk), .rst(rst),
    .in_valid(v[8]), .in_ready(div_ready), .in_data(div_in),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(div_out)
  );

  assign m_axis_tdata = {div_out.sy, div_out.sx, div_out.z, div_out.y, div_out.x};
  assign m_axis_tuser = div_out.fault;
  assign m_axis_tlast = div_out.last;

  // A stalled item at the end of the transform section stays put
  assert property (@(posedge clk) disable iff (rst) v[8] && !en[9] |=> v[8])
    else $error("transform output dropped while divider stalled");

  // Full transform section with a stalled divider must refuse input
  assert property (@(posedge clk) disable iff (rst) (&v) && !div_ready |-> !s_axis_tready)
    else $error("input accepted into a full stalled pipeline");

  // A divide fault reports zero pixels
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:96] == '0)
    else $error("nonzero screen position on divide fault");

endmodule
